// ===== design/aigsh_pkg.sv =====
// Shared types and constants for the AIG structural hashing node builder.
package aigsh_pkg;

   localparam int unsigned LIT_W         = 11;
   localparam int unsigned KEY_W         = 2 * LIT_W;
   localparam int unsigned MAX_NODES_DEF = 1024;

   localparam logic [LIT_W-1:0] LIT_FALSE = 11'd0;
   localparam logic [LIT_W-1:0] LIT_TRUE  = 11'd1;

   localparam logic MODE_INPUT = 1'b0;
   localparam logic MODE_AND   = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_PROBE,
      ST_DONE
   } state_type;

   // Outcome of the operand folding and ordering step.
   typedef struct packed {
      logic             folded;
      logic [LIT_W-1:0] lit;
      logic [KEY_W-1:0] key;
   } fold_type;

endpackage

// ===== design/aigsh_req_if.sv =====
// Request channel: node allocation or AND of two literals.
interface aigsh_req_if;
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic [aigsh_pkg::LIT_W-1:0]  lit_a;
   logic [aigsh_pkg::LIT_W-1:0]  lit_b;

   modport source (output valid, mode, lit_a, lit_b, input ready);
   modport sink   (input valid, mode, lit_a, lit_b, output ready);
endinterface

// ===== design/aigsh_rsp_if.sv =====
// Response channel: resulting literal, status flags and node count.
interface aigsh_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [aigsh_pkg::LIT_W-1:0]  result_lit;
   logic                         created;
   logic                         full_res;
   logic [aigsh_pkg::LIT_W-1:0]  node_total;

   modport source (output valid, result_lit, created, full_res, node_total, input ready);
   modport sink   (input valid, result_lit, created, full_res, node_total, output ready);
endinterface

// ===== design/aigsh_ram.sv =====
// Generic simple dual-port RAM with registered read.
module aigsh_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

// ===== design/aigsh_fold.sv =====
// Operand folding, ordering and pair-table hash for AND requests.
module aigsh_fold #(
   parameter int unsigned HASH_W = 11
) (
   input  logic [aigsh_pkg::LIT_W-1:0] lit_a,
   input  logic [aigsh_pkg::LIT_W-1:0] lit_b,
   output aigsh_pkg::fold_type         fold,
   output logic [HASH_W-1:0]           hash
);

   localparam int unsigned LIT_W = aigsh_pkg::LIT_W;
   localparam int unsigned KEY_W = aigsh_pkg::KEY_W;

   always_comb begin
      fold.folded = 1'b1;
      fold.lit    = aigsh_pkg::LIT_FALSE;
      fold.key    = (lit_a < lit_b) ? {lit_a, lit_b} : {lit_b, lit_a};
      if (lit_a == aigsh_pkg::LIT_FALSE || lit_b == aigsh_pkg::LIT_FALSE) begin
         fold.lit = aigsh_pkg::LIT_FALSE;
      end else if (lit_a == aigsh_pkg::LIT_TRUE) begin
         fold.lit = lit_b;
      end else if (lit_b == aigsh_pkg::LIT_TRUE || lit_a == lit_b) begin
         fold.lit = lit_a;
      end else if (lit_a[LIT_W-1:1] == lit_b[LIT_W-1:1]) begin
         // x AND NOT x
         fold.lit = aigsh_pkg::LIT_FALSE;
      end else begin
         fold.folded = 1'b0;
      end
   end

   // XOR fold of the key down to the table address width
   always_comb begin
      hash = '0;
      for (int i = 0; i < KEY_W; i++) begin
         hash[i % HASH_W] ^= fold.key[i];
      end
   end

endmodule

// ===== design/aig_structural_hash_and.sv =====
// Flow: an accepted request passes through DECODE and then DONE for input nodes and
// folded ANDs; other ANDs take the PROBE state once per pair-table probe in between.
// The response is registered when DONE finds the output free; no new request is taken before that. Each
// probe is one read of the single pair-table RAM (open addressing, linear).
// Reset (synchronous): node count returns to 1 and a clearing pass writes all
// 2 * 2**clog2(MAX_NODES) pair-table entries empty before requests are taken.
module aig_structural_hash_and #(
   parameter int unsigned MAX_NODES = aigsh_pkg::MAX_NODES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   aigsh_req_if.sink   req_bus,
   aigsh_rsp_if.source rsp_bus
);

   localparam int unsigned LIT_W     = aigsh_pkg::LIT_W;
   localparam int unsigned KEY_W     = aigsh_pkg::KEY_W;
   localparam int unsigned ID_W      = $clog2(MAX_NODES);
   localparam int unsigned CNT_W     = $clog2(MAX_NODES + 1);
   localparam int unsigned TBL_AW    = ID_W + 1;
   localparam int unsigned TBL_DEPTH = 1 << TBL_AW;
   localparam int unsigned ENTRY_W   = 1 + KEY_W + ID_W;

   aigsh_pkg::state_type state_ff, state_in;

   logic                mode_ff, mode_in;
   logic [LIT_W-1:0]    lit_a_ff, lit_a_in;
   logic [LIT_W-1:0]    lit_b_ff, lit_b_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [TBL_AW-1:0]   probe_addr_ff, probe_addr_in;
   logic [CNT_W-1:0]    node_count_ff, node_count_in;

   logic [LIT_W-1:0]    res_lit_ff, res_lit_in;
   logic                res_created_ff, res_created_in;
   logic                res_full_ff, res_full_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [LIT_W-1:0]    rsp_lit_ff, rsp_lit_in;
   logic                rsp_created_ff, rsp_created_in;
   logic                rsp_full_ff, rsp_full_in;
   logic [LIT_W-1:0]    rsp_total_ff, rsp_total_in;

   logic                tbl_we;
   logic [TBL_AW-1:0]   tbl_waddr;
   logic [ENTRY_W-1:0]  tbl_wdata;
   logic                tbl_re;
   logic [TBL_AW-1:0]   tbl_raddr;
   logic [ENTRY_W-1:0]  tbl_rdata;

   aigsh_pkg::fold_type fold;
   logic [TBL_AW-1:0]   hash;

   logic                entry_valid;
   logic [KEY_W-1:0]    entry_key;
   logic [ID_W-1:0]     entry_node;
   logic [ID_W:0]       entry_lit_wide;
   logic [ID_W:0]       new_lit_wide;
   logic [LIT_W-1:0]    new_lit;
   logic                store_full;
   logic                out_free;
   logic                req_ready;

   aigsh_fold #(
      .HASH_W (TBL_AW)
   ) u_fold (
      .lit_a (lit_a_ff),
      .lit_b (lit_b_ff),
      .fold  (fold),
      .hash  (hash)
   );

   aigsh_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TBL_DEPTH)
   ) u_pair_tbl (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (tbl_wdata),
      .re    (tbl_re),
      .raddr (tbl_raddr),
      .rdata (tbl_rdata)
   );

   // entry layout: {valid, key, node}
   assign entry_valid    = tbl_rdata[ENTRY_W-1];
   assign entry_key      = tbl_rdata[ENTRY_W-2 -: KEY_W];
   assign entry_node     = tbl_rdata[ID_W-1:0];
   assign entry_lit_wide = {entry_node, 1'b0};
   assign new_lit_wide   = {node_count_ff[ID_W-1:0], 1'b0};
   assign new_lit        = LIT_W'(new_lit_wide);
   assign store_full     = (node_count_ff == CNT_W'(MAX_NODES));
   assign out_free       = !rsp_valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= aigsh_pkg::ST_CLEAR;
         probe_addr_ff  <= '0;
         node_count_ff  <= CNT_W'(1);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         probe_addr_ff  <= probe_addr_in;
         node_count_ff  <= node_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      mode_ff        <= mode_in;
      lit_a_ff       <= lit_a_in;
      lit_b_ff       <= lit_b_in;
      key_ff         <= key_in;
      res_lit_ff     <= res_lit_in;
      res_created_ff <= res_created_in;
      res_full_ff    <= res_full_in;
      rsp_lit_ff     <= rsp_lit_in;
      rsp_created_ff <= rsp_created_in;
      rsp_full_ff    <= rsp_full_in;
      rsp_total_ff   <= rsp_total_in;
   end

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      lit_a_in       = lit_a_ff;
      lit_b_in       = lit_b_ff;
      key_in         = key_ff;
      probe_addr_in  = probe_addr_ff;
      node_count_in  = node_count_ff;
      res_lit_in     = res_lit_ff;
      res_created_in = res_created_ff;
      res_full_in    = res_full_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_lit_in     = rsp_lit_ff;
      rsp_created_in = rsp_created_ff;
      rsp_full_in    = rsp_full_ff;
      rsp_total_in   = rsp_total_ff;
      tbl_we         = 1'b0;
      tbl_waddr      = probe_addr_ff;
      tbl_wdata      = '0;
      tbl_re         = 1'b0;
      tbl_raddr      = hash;
      req_ready      = 1'b0;

      case (state_ff)
         aigsh_pkg::ST_CLEAR: begin
            tbl_we        = 1'b1;
            probe_addr_in = probe_addr_ff + TBL_AW'(1);
            if (probe_addr_ff == '1) begin
               state_in = aigsh_pkg::ST_IDLE;
            end
         end
         aigsh_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_bus.valid) begin
               mode_in  = req_bus.mode;
               lit_a_in = req_bus.lit_a;
               lit_b_in = req_bus.lit_b;
               state_in = aigsh_pkg::ST_DECODE;
            end
         end
         aigsh_pkg::ST_DECODE: begin
            res_created_in = 1'b0;
            res_full_in    = 1'b0;
            state_in       = aigsh_pkg::ST_DONE;
            if (mode_ff == aigsh_pkg::MODE_INPUT) begin
               if (store_full) begin
                  res_lit_in  = aigsh_pkg::LIT_FALSE;
                  res_full_in = 1'b1;
               end else begin
                  res_lit_in     = new_lit;
                  res_created_in = 1'b1;
                  node_count_in  = node_count_ff + CNT_W'(1);
               end
            end else if (fold.folded) begin
               res_lit_in = fold.lit;
            end else begin
               tbl_re        = 1'b1;
               tbl_raddr     = hash;
               probe_addr_in = hash;
               key_in        = fold.key;
               state_in      = aigsh_pkg::ST_PROBE;
            end
         end
         aigsh_pkg::ST_PROBE: begin
            res_created_in = 1'b0;
            res_full_in    = 1'b0;
            if (entry_valid && entry_key == key_ff) begin
               res_lit_in = LIT_W'(entry_lit_wide);
               state_in   = aigsh_pkg::ST_DONE;
            end else if (!entry_valid) begin
               // empty slot ends the chain: the pair is new
               state_in = aigsh_pkg::ST_DONE;
               if (store_full) begin
                  res_lit_in  = aigsh_pkg::LIT_FALSE;
                  res_full_in = 1'b1;
               end else begin
                  tbl_we         = 1'b1;
                  tbl_wdata      = {1'b1, key_ff, node_count_ff[ID_W-1:0]};
                  res_lit_in     = new_lit;
                  res_created_in = 1'b1;
                  node_count_in  = node_count_ff + CNT_W'(1);
               end
            end else begin
               probe_addr_in = probe_addr_ff + TBL_AW'(1);
               tbl_re        = 1'b1;
               tbl_raddr     = probe_addr_ff + TBL_AW'(1);
            end
         end
         aigsh_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_lit_in     = res_lit_ff;
               rsp_created_in = res_created_ff;
               rsp_full_in    = res_full_ff;
               rsp_total_in   = LIT_W'(node_count_ff);
               state_in       = aigsh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = aigsh_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_bus.ready      = req_ready;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.result_lit = rsp_lit_ff;
   assign rsp_bus.created    = rsp_created_ff;
   assign rsp_bus.full_res   = rsp_full_ff;
   assign rsp_bus.node_total = rsp_total_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      node_count_ff >= CNT_W'(1) && node_count_ff <= CNT_W'(MAX_NODES))
      else $error("node count out of range");

   a_insert_empty: assert property (@(posedge clock) disable iff (reset)
      tbl_we && state_ff == aigsh_pkg::ST_PROBE |-> !entry_valid)
      else $error("pair insert over an occupied slot");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      tbl_we && state_ff == aigsh_pkg::ST_PROBE
      |=> node_count_ff == $past(node_count_ff) + CNT_W'(1))
      else $error("pair insert without node allocation");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      state_ff == aigsh_pkg::ST_DONE && res_full_ff |-> store_full && !res_created_ff)
      else $error("full flag raised with free store");

endmodule
